FILE: rtl/core/deq_pkg.sv
// Shared definitions for the double-ended queue: field widths, request and
// status codes, and the result descriptor passed from sequencer to top level.
// No dependencies.
package deq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    // request codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST      = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                from_ram;  // value comes from the RAM read port
        logic                last;
    } res_meta_t;

endpackage

FILE: rtl/core/deq_ram.sv
// Generic single-port synchronous RAM with registered read.
// Read data holds while no read is issued. No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/deq_seq.sv
// Request sequencer: head index, occupancy, listing walk and RAM access issue.
// Depends on deq_pkg.
module deq_seq #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [deq_pkg::MODE_W-1:0]       mode,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    input  logic                             adv,
    output logic                             ram_we,
    output logic                             ram_re,
    output logic [IDX_W-1:0]                 ram_addr,
    output logic [deq_pkg::DATA_W-1:0]       ram_wdata,
    output logic                             p1_valid,
    output deq_pkg::res_meta_t               p1_meta
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic               state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   lidx_reg, lidx_next;
    logic               p1_valid_reg, p1_valid_next;
    deq_pkg::res_meta_t p1_meta_reg, p1_meta_next;

    logic             issue_ok, issue, acc, full, empty, list_last;
    logic [IDX_W-1:0] head_m1;

    // ring position head + off, off below DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] h,
                                                  input logic [CNT_W-1:0] off);
        logic [IDX_W+1:0] s;
        s = {2'b00, h} + (IDX_W+2)'(off);
        if (s >= (IDX_W+2)'(DEPTH))
        begin
            s = s - (IDX_W+2)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign issue_ok  = !p1_valid_reg || adv;
    assign req_ready = (state_reg == S_IDLE) && issue_ok;
    assign acc       = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_m1   = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign list_last = ({1'b0, lidx_reg} + 1'b1) == {1'b0, count_reg};
    assign ram_wdata = value;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        lidx_next    = lidx_reg;
        p1_meta_next = p1_meta_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = head_reg;
        issue        = 1'b0;
        if (state_reg == S_LIST)
        begin
            if (issue_ok)
            begin
                ram_re       = 1'b1;
                ram_addr     = wrap_add(head_reg, lidx_reg);
                issue        = 1'b1;
                p1_meta_next = '{deq_pkg::STAT_OK, 1'b1, list_last};
                lidx_next    = lidx_reg + 1'b1;
                if (list_last)
                begin
                    state_next = S_IDLE;
                end
            end
        end
        else if (acc)
        begin
            unique case (mode)
                deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_BACK:
                begin
                    issue = 1'b1;
                    if (full)
                    begin
                        p1_meta_next = '{deq_pkg::STAT_FULL, 1'b0, 1'b1};
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        count_next   = count_reg + 1'b1;
                        p1_meta_next = '{deq_pkg::STAT_OK, 1'b0, 1'b1};
                        if (mode == deq_pkg::MODE_INS_FRONT)
                        begin
                            ram_addr  = head_m1;
                            head_next = head_m1;
                        end
                        else
                        begin
                            ram_addr = wrap_add(head_reg, count_reg);
                        end
                    end
                end
                deq_pkg::MODE_REM_FRONT, deq_pkg::MODE_REM_BACK:
                begin
                    issue = 1'b1;
                    if (empty)
                    begin
                        p1_meta_next = '{deq_pkg::STAT_EMPTY, 1'b0, 1'b1};
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        count_next   = count_reg - 1'b1;
                        p1_meta_next = '{deq_pkg::STAT_OK, 1'b1, 1'b1};
                        if (mode == deq_pkg::MODE_REM_FRONT)
                        begin
                            ram_addr  = head_reg;
                            head_next = wrap_add(head_reg, CNT_W'(1));
                        end
                        else
                        begin
                            ram_addr = wrap_add(head_reg, count_reg - 1'b1);
                        end
                    end
                end
                deq_pkg::MODE_LIST:
                begin
                    issue = 1'b1;
                    if (empty)
                    begin
                        p1_meta_next = '{deq_pkg::STAT_EMPTY, 1'b0, 1'b1};
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_addr     = head_reg;
                        p1_meta_next = '{deq_pkg::STAT_OK, 1'b1,
                                         count_reg == CNT_W'(1)};
                        if (count_reg != CNT_W'(1))
                        begin
                            state_next = S_LIST;
                            lidx_next  = CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    // undefined modes: drop silently
                end
            endcase
        end
    end

    always_comb
    begin
        if (issue)
        begin
            p1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            p1_valid_next = 1'b0;
        end
        else
        begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            lidx_reg     <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            lidx_reg     <= lidx_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_meta_reg <= p1_meta_next;
    end

    assign p1_valid = p1_valid_reg;
    assign p1_meta  = p1_meta_reg;

endmodule

FILE: rtl/core/double_ended_queue.sv
// Top level of the bounded double-ended queue: sequencer, entry RAM and
// result output register. Depends on deq_pkg, deq_ram and deq_seq.
//
// Usage:
//   Request channel (req_valid/req_ready, mode, value) carries one request
//   per beat: insert front/back, remove front/back, or list all entries.
//   Result channel (res_valid/res_ready, status, value_res, last) returns
//   one beat per insert or remove, and one beat per stored entry for a
//   listing (a single empty beat if nothing is stored); last marks the
//   final beat of each request. Undefined modes produce no beat.
//   The first result beat of a request passes through the RAM read stage
//   and then the output register. Inserts and removals are accepted back
//   to back, one per cycle while the receiver does not stall; a listing
//   issues one RAM read per entry through the single RAM port, and holds
//   off new requests until its last read issues.
//   Reset clears head index, occupancy and all valid flags at once; the
//   entry RAM is not cleared, since no entry is read before being written.
//   When the receiver stalls, the output register holds its beat, the
//   one-deep RAM-read stage behind it holds, and req_ready drops until the
//   output register frees again. Nothing is lost while stalled.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [deq_pkg::MODE_W-1:0]        mode,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [deq_pkg::STATUS_W-1:0]      status,
    output logic signed [deq_pkg::DATA_W-1:0] value_res,
    output logic                              last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         ram_we, ram_re;
    logic [IDX_W-1:0]             ram_addr;
    logic [deq_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;
    logic                         p1_valid;
    deq_pkg::res_meta_t           p1_meta;

    logic                         out_free, load;
    logic                         res_valid_reg, res_valid_next;
    logic [deq_pkg::STATUS_W-1:0] status_reg;
    logic [deq_pkg::DATA_W-1:0]   value_reg;
    logic                         last_reg;

    deq_seq #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .mode      (mode),
        .value     (value),
        .adv       (out_free),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .p1_valid  (p1_valid),
        .p1_meta   (p1_meta)
    );

    // A write and a read never share a cycle; a read of an entry written in
    // the previous cycle sees the new data, so no forwarding path is needed.
    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Advance the read stage into the output register whenever it is free.
    assign out_free = !res_valid_reg || res_ready;
    assign load     = p1_valid && out_free;

    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= p1_meta.status;
            value_reg  <= p1_meta.from_ram ? ram_rdata : '0;
            last_reg   <= p1_meta.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign value_res = value_reg;
    assign last      = last_reg;

    // No request is taken while the read stage is blocked behind a stall.
    a_no_accept_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        (p1_valid && !out_free) |-> !(req_valid && req_ready))
        else $error("request accepted while read stage blocked");

    // A defined request always produces a result in the read stage.
    a_request_issues: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && mode <= deq_pkg::MODE_LIST) |=> p1_valid)
        else $error("accepted request produced no result");

    // Empty and full results carry a zero value and close the request.
    a_refusal_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && status != deq_pkg::STAT_OK) |-> (value_res == '0 && last))
        else $error("refusal result malformed");

endmodule

FILE: tb/sv/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: a request driver and a
// result monitor around a cycle-free model of the ring store.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int DEPTH       = deq_pkg::DEPTH_DEF;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int RANDOM_REQS = 300;
    localparam int MAX_GAP     = 6;
    localparam int HOLD_EVERY  = 500;     // long receiver hold, once per this many beats
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 300;
    localparam int SETTLE      = 20;      // margin for stray beats to surface before the verdict
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef logic [deq_pkg::MODE_W-1:0] mode_code_t;

    // request codes the block must ignore
    localparam mode_code_t MODE_JUNK_LO = deq_pkg::MODE_LIST + 1'b1;
    localparam mode_code_t MODE_JUNK_HI = '1;

    typedef struct {
        logic [deq_pkg::MODE_W-1:0]        mode;
        logic signed [deq_pkg::DATA_W-1:0] value;
        int unsigned                       gap;          // idle cycles before this beat
        bit                                drain_first;  // wait until all results are in
    } deq_req_t;

    typedef struct {
        logic [deq_pkg::STATUS_W-1:0]      status;
        logic signed [deq_pkg::DATA_W-1:0] value_res;
        logic                              last;
    } deq_beat_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              req_valid = 1'b0;
    logic                              req_ready;
    logic [deq_pkg::MODE_W-1:0]        mode      = deq_pkg::MODE_INS_FRONT;
    logic signed [deq_pkg::DATA_W-1:0] value     = '0;
    logic                              res_valid;
    logic                              res_ready = 1'b0;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic signed [deq_pkg::DATA_W-1:0] value_res;
    logic                              last;

    // request plan, filled once at time zero and drained by the driver
    deq_req_t  req_plan[$];
    int        plan_reqs = 0;     // meaningful requests planned so far
    int        plan_occ  = 0;     // occupancy the plan expects, steers the phases

    // shadow of the ring store, advanced once per accepted request beat
    logic signed [deq_pkg::DATA_W-1:0] model_store[DEPTH];
    logic [IDX_W-1:0]                  model_head = '0;
    logic [IDX_W:0]                    model_occ  = '0;

    // result beats still owed by the block, oldest first
    deq_beat_t due_beats[$];
    int        beats_due_total  = 0;   // driver side, blocking
    int        beats_due_q      = 0;   // registered copy read by the monitor
    int        beats_seen_total = 0;   // monitor side, blocking
    int        beats_seen_q     = 0;   // registered copy read by the driver

    deq_req_t    next_req;
    bit          offer_busy;
    bit          gap_armed  = 1'b0;
    int unsigned idle_left  = 0;
    int unsigned stall_left = 0;
    deq_beat_t   want_beat;
    int          mismatches = 0;
    int          cycle_count = 0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .mode     (mode),
        .value    (value),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .status   (status),
        .value_res(value_res),
        .last     (last)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // Plan construction
    // ---------------------------------------------------------------------

    // Append one request and track the occupancy it leaves behind.
    function automatic void plan_req(input logic [deq_pkg::MODE_W-1:0] m,
                                     input logic signed [deq_pkg::DATA_W-1:0] v,
                                     input int unsigned gap,
                                     input bit drain_first);
        deq_req_t r;
        r.mode        = m;
        r.value       = v;
        r.gap         = gap;
        r.drain_first = drain_first;
        req_plan.push_back(r);
        if ((m == deq_pkg::MODE_INS_FRONT || m == deq_pkg::MODE_INS_BACK) &&
            plan_occ < DEPTH)
            plan_occ++;
        else if ((m == deq_pkg::MODE_REM_FRONT || m == deq_pkg::MODE_REM_BACK) &&
                 plan_occ > 0)
            plan_occ--;
        if (m <= deq_pkg::MODE_LIST)
            plan_reqs++;
    endfunction

    // Lean on the extremes now and then, else any 32-bit pattern.
    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::MODE_W-1:0] pick_insert();
        return $urandom_range(0, 1) ? deq_pkg::MODE_INS_BACK : deq_pkg::MODE_INS_FRONT;
    endfunction

    function automatic logic [deq_pkg::MODE_W-1:0] pick_remove();
        return $urandom_range(0, 1) ? deq_pkg::MODE_REM_BACK : deq_pkg::MODE_REM_FRONT;
    endfunction

    // ---------------------------------------------------------------------
    // Model of the ring store
    // ---------------------------------------------------------------------

    function automatic void owe_beat(input logic [deq_pkg::STATUS_W-1:0] st,
                                     input logic signed [deq_pkg::DATA_W-1:0] v,
                                     input logic lst);
        deq_beat_t b;
        b.status    = st;
        b.value_res = v;
        b.last      = lst;
        due_beats.push_back(b);
        beats_due_total++;
    endfunction

    // Advance the shadow store by one request and queue the beats it owes.
    function automatic void apply_request(input logic [deq_pkg::MODE_W-1:0] m,
                                          input logic signed [deq_pkg::DATA_W-1:0] v);
        int unsigned slot;
        int unsigned i;
        case (m)
            deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_BACK:
            begin
                if (model_occ == DEPTH)
                    owe_beat(deq_pkg::STAT_FULL, '0, 1'b1);
                else
                begin
                    if (m == deq_pkg::MODE_INS_FRONT)
                    begin
                        model_head = IDX_W'((model_head + DEPTH - 1) % DEPTH);
                        slot       = model_head;
                    end
                    else
                        slot = (model_head + model_occ) % DEPTH;
                    model_store[slot] = v;
                    model_occ++;
                    owe_beat(deq_pkg::STAT_OK, '0, 1'b1);
                end
            end
            deq_pkg::MODE_REM_FRONT, deq_pkg::MODE_REM_BACK:
            begin
                if (model_occ == 0)
                    owe_beat(deq_pkg::STAT_EMPTY, '0, 1'b1);
                else
                begin
                    if (m == deq_pkg::MODE_REM_FRONT)
                    begin
                        slot       = model_head;
                        model_head = IDX_W'((model_head + 1) % DEPTH);
                    end
                    else
                        slot = (model_head + model_occ - 1) % DEPTH;
                    model_occ--;
                    owe_beat(deq_pkg::STAT_OK, model_store[slot], 1'b1);
                end
            end
            deq_pkg::MODE_LIST:
            begin
                if (model_occ == 0)
                    owe_beat(deq_pkg::STAT_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < model_occ; i++)
                        owe_beat(deq_pkg::STAT_OK,
                                 model_store[(model_head + i) % DEPTH],
                                 (i + 1 == model_occ));
            end
            default: ;  // undefined request codes leave no trace
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request driver: one beat per accepted item, gaps drawn per item
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            mode      <= deq_pkg::MODE_INS_FRONT;
            value     <= '0;
        end
        else
        begin
            offer_busy = req_valid;
            if (req_valid && req_ready)
            begin
                apply_request(mode, value);
                beats_due_q <= beats_due_total;
                offer_busy = 1'b0;
            end
            if (!offer_busy)
            begin
                // arm the gap of the next item once, then count it down
                if (req_plan.size() != 0 && !gap_armed)
                begin
                    idle_left = req_plan[0].gap;
                    gap_armed = 1'b1;
                end
                if (req_plan.size() != 0 && idle_left == 0 &&
                    !(req_plan[0].drain_first && beats_due_total != beats_seen_q))
                begin
                    next_req  = req_plan.pop_front();
                    gap_armed = 1'b0;
                    req_valid <= 1'b1;
                    mode      <= next_req.mode;
                    value     <= next_req.value;
                end
                else
                begin
                    if (idle_left > 0)
                        idle_left--;
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: check each beat against the oldest owed one
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                // only beats owed before this edge count, so the driver's
                // pushes in the same step cannot satisfy this one
                if (beats_seen_total < beats_due_q)
                begin
                    want_beat = due_beats.pop_front();
                    if (status !== want_beat.status)
                    begin
                        $error("status: expected %0d, got %0d", want_beat.status, status);
                        mismatches++;
                    end
                    if (value_res !== want_beat.value_res)
                    begin
                        $error("value_res: expected %0d, got %0d",
                               want_beat.value_res, value_res);
                        mismatches++;
                    end
                    if (last !== want_beat.last)
                    begin
                        $error("last: expected %0d, got %0d", want_beat.last, last);
                        mismatches++;
                    end
                    beats_seen_total++;
                    beats_seen_q <= beats_seen_total;
                end
                else
                begin
                    $error("unexpected beat: status %0d, value_res %0d, last %0d",
                           status, value_res, last);
                    mismatches++;
                end
                // stretches of full-rate draining alternate with random stalls
                stall_left = ((beats_seen_total / 64) % 3 == 0) ?
                             0 : $urandom_range(0, MAX_GAP);
                // hold off long enough to back the block up into its input
                if (beats_seen_total % HOLD_EVERY == HOLD_AT)
                    stall_left = HOLD_LEN;
            end
            else if (stall_left > 0)
                stall_left--;
            res_ready <= (stall_left == 0);
        end
    end

    // Stop a hung run; a beat that never shows up ends here too.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ---------------------------------------------------------------------
    initial
    begin
        int          phase_kind;
        int          random_start;
        int          roll;
        bit          no_idle;
        bit          sync_next;
        int unsigned gap;

        // Directed part: empty store corner cases, junk codes, extremes.
        plan_req(deq_pkg::MODE_LIST, '0, 0, 1'b0);        // listing of an empty store
        plan_req(deq_pkg::MODE_REM_FRONT, '0, 0, 1'b0);   // remove from empty, both ends
        plan_req(deq_pkg::MODE_REM_BACK, '1, 1, 1'b0);
        plan_req(MODE_JUNK_LO, 32'sh1234_5678, 0, 1'b0);
        plan_req(deq_pkg::MODE_LIST + 3'd2, '1, 2, 1'b0);
        plan_req(MODE_JUNK_HI, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_INS_FRONT, 32'sh7FFF_FFFF, 0, 1'b0);
        plan_req(deq_pkg::MODE_INS_BACK, 32'sh8000_0000, 0, 1'b0);
        plan_req(deq_pkg::MODE_INS_FRONT, '0, 3, 1'b0);
        plan_req(deq_pkg::MODE_INS_BACK, '1, 0, 1'b0);
        plan_req(deq_pkg::MODE_INS_FRONT, 32'sh5555_5555, 0, 1'b0);
        plan_req(deq_pkg::MODE_INS_BACK, 32'shAAAA_AAAA, 0, 1'b0);
        plan_req(deq_pkg::MODE_LIST, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_REM_FRONT, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_REM_BACK, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_LIST, '0, 1, 1'b0);
        plan_req(deq_pkg::MODE_REM_BACK, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_REM_FRONT, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_REM_FRONT, '0, 0, 1'b0);
        plan_req(deq_pkg::MODE_REM_BACK, '0, 0, 1'b0);    // store now empty again
        plan_req(deq_pkg::MODE_REM_BACK, '0, 0, 1'b0);

        // Random part: fill to full, drain to empty, or mix, with random data.
        random_start = plan_reqs;
        sync_next    = 1'b1;
        while (plan_reqs - random_start < RANDOM_REQS)
        begin
            phase_kind = $urandom_range(0, 2);
            no_idle    = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0)
                sync_next = 1'b1;
            case (phase_kind)
                0:
                begin
                    // fill, then knock on the full store
                    while (plan_occ < DEPTH)
                    begin
                        roll = $urandom_range(0, 99);
                        gap  = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                        if (roll < 2)
                            plan_req(deq_pkg::MODE_LIST, pick_value(), gap, sync_next);
                        else if (roll < 12)
                            plan_req(pick_remove(), pick_value(), gap, sync_next);
                        else
                            plan_req(pick_insert(), pick_value(), gap, sync_next);
                        sync_next = 1'b0;
                    end
                    repeat ($urandom_range(1, 3))
                        plan_req(pick_insert(), pick_value(),
                                 no_idle ? 0 : $urandom_range(0, MAX_GAP), 1'b0);
                    if ($urandom_range(0, 1))
                        plan_req(deq_pkg::MODE_LIST, '0, 0, 1'b0);
                end
                1:
                begin
                    // drain, then remove past empty
                    while (plan_occ > 0)
                    begin
                        roll = $urandom_range(0, 99);
                        gap  = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                        if (roll < 2)
                            plan_req(deq_pkg::MODE_LIST, pick_value(), gap, sync_next);
                        else if (roll < 12)
                            plan_req(pick_insert(), pick_value(), gap, sync_next);
                        else
                            plan_req(pick_remove(), pick_value(), gap, sync_next);
                        sync_next = 1'b0;
                    end
                    repeat ($urandom_range(1, 2))
                        plan_req(pick_remove(), pick_value(),
                                 no_idle ? 0 : $urandom_range(0, MAX_GAP), 1'b0);
                    if ($urandom_range(0, 2) == 0)
                        plan_req(deq_pkg::MODE_LIST, '0, 0, 1'b0);
                end
                default:
                begin
                    // any request, a little junk mixed in
                    repeat ($urandom_range(20, 40))
                    begin
                        roll = $urandom_range(0, 99);
                        gap  = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                        if (roll < 4)
                            plan_req(mode_code_t'($urandom_range(MODE_JUNK_LO,
                                                                 MODE_JUNK_HI)),
                                     pick_value(), gap, sync_next);
                        else if (roll < 7)
                            plan_req(deq_pkg::MODE_LIST, pick_value(), gap, sync_next);
                        else if (roll < 55)
                            plan_req(pick_insert(), pick_value(), gap, sync_next);
                        else
                            plan_req(pick_remove(), pick_value(), gap, sync_next);
                        sync_next = 1'b0;
                    end
                end
            endcase
        end

        // Hold reset while the clock runs, then release it for good.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, away from the clocked processes.
        do
            @(negedge clk);
        while (req_plan.size() != 0 || req_valid || beats_due_total != beats_seen_total);

        // Let stray beats surface before the verdict.
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
